[sv/bba_pkg.sv]
package bba_pkg;

  // Disk geometry
  localparam int TOTAL_BLOCKS    = 20480;
  localparam int WORD_BITS       = 64;
  localparam int WORD_COUNT      = (TOTAL_BLOCKS + WORD_BITS - 1) / WORD_BITS;
  localparam int ADDR_W          = $clog2(WORD_COUNT);
  localparam int BIT_W           = $clog2(WORD_BITS);
  localparam int IDX_W           = 15;
  localparam int RESERVED_BLOCKS = 6;

  typedef logic [WORD_BITS-1:0] word_t;
  typedef logic [ADDR_W-1:0]    addr_t;
  typedef logic [BIT_W-1:0]     bitpos_t;
  typedef logic [IDX_W-1:0]     index_t;

  localparam addr_t  LAST_WORD     = addr_t'(WORD_COUNT - 1);
  localparam index_t INDEX_END     = index_t'(TOTAL_BLOCKS);
  localparam index_t LIMIT_RESET   = index_t'(16384);
  localparam word_t  RESERVED_MASK = word_t'((64'd1 << RESERVED_BLOCKS) - 64'd1);

  // Operation codes carried on in_tuser
  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  // Result status carried on out_tuser
  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NO_SPACE = 2'd1,
    ST_RANGE    = 2'd2
  } status_t;

  // Controller states
  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN,
    S_FREE,
    S_RESP
  } state_t;

endpackage

[sv/bitmap_block_allocator.sv]
// Channel | Dir | Signals                     | Contents (low bit first)
// in      | in  | in_tvalid/tready/tdata/tuser| tdata: block_index[14:0], 0; tuser: operation
// out     | out | out_tvalid/tready/tdata/tuser| tdata: allocated_index[14:0], 0; tuser: status
// cfg     | in  | cfg_wr_en/cfg_wr_data       | alloc_limit[14:0]
//
// After reset a clearing pass writes all 320 bitmap words, with the input held off.
// Allocate: the scan reads words from word 0 until the first one with a clear bit;
// the bitmap RAM streams one 64-bit word per cycle through a first-zero encoder.
// Free: read, modify/write, respond; an out-of-range free goes straight to respond.
// One transaction is in flight at a time; a finished result waits in the output
// register while the next transaction is accepted, and a full output register stalls
// only the response step.
module bitmap_block_allocator
  import bba_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [14:0] block_index, [15] zero
  input  logic        in_tuser,   // [0] operation
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [14:0] allocated_index, [15] zero
  output logic [1:0]  out_tuser,  // [1:0] status
  input  logic        cfg_wr_en,
  input  logic [14:0] cfg_wr_data // [14:0] alloc_limit
);

  // Bitmap RAM
  word_t   mem [WORD_COUNT];
  word_t   mem_rdata_r;
  logic    mem_we;
  logic    mem_re;
  addr_t   mem_waddr;
  addr_t   mem_raddr;
  word_t   mem_wdata;

  state_t  state_r, state_nxt;
  addr_t   clr_addr_r, clr_addr_nxt;
  addr_t   chk_addr_r, chk_addr_nxt;
  bitpos_t free_bit_r, free_bit_nxt;
  index_t  res_index_r, res_index_nxt;
  status_t res_status_r, res_status_nxt;
  index_t  alloc_limit_r;

  logic    out_valid_r;
  index_t  out_index_r;
  status_t out_status_r;
  logic    load_out;

  bitpos_t ffz;
  logic    has_zero;
  index_t  found_idx;
  index_t  req_idx;

  assign req_idx = in_tdata[IDX_W-1:0];

  // RAM: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      mem_rdata_r <= mem[mem_raddr];
    end
  end

  // Lowest clear bit of the word just read
  always_comb begin
    ffz      = '0;
    has_zero = 1'b0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (!mem_rdata_r[i]) begin
        ffz      = bitpos_t'(i);
        has_zero = 1'b1;
      end
    end
  end

  assign found_idx = index_t'({chk_addr_r, ffz});

  // Limit register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      alloc_limit_r <= LIMIT_RESET;
    end else if (cfg_wr_en) begin
      alloc_limit_r <= cfg_wr_data;
    end
  end

  // State registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_CLEAR;
      clr_addr_r <= '0;
    end else begin
      state_r    <= state_nxt;
      clr_addr_r <= clr_addr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    chk_addr_r   <= chk_addr_nxt;
    free_bit_r   <= free_bit_nxt;
    res_index_r  <= res_index_nxt;
    res_status_r <= res_status_nxt;
  end

  // Next state and datapath control
  always_comb begin
    state_nxt      = state_r;
    clr_addr_nxt   = clr_addr_r;
    chk_addr_nxt   = chk_addr_r;
    free_bit_nxt   = free_bit_r;
    res_index_nxt  = res_index_r;
    res_status_nxt = res_status_r;
    mem_we         = 1'b0;
    mem_waddr      = chk_addr_r;
    mem_wdata      = mem_rdata_r;
    mem_re         = 1'b0;
    mem_raddr      = chk_addr_r + addr_t'(1);
    in_tready      = 1'b0;
    load_out       = 1'b0;

    unique case (state_r)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_addr_r;
        mem_wdata = (clr_addr_r == '0) ? RESERVED_MASK : '0;
        if (clr_addr_r == LAST_WORD) begin
          state_nxt = S_IDLE;
        end else begin
          clr_addr_nxt = clr_addr_r + addr_t'(1);
        end
      end

      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          if (in_tuser == OP_ALLOC) begin
            mem_re       = 1'b1;
            mem_raddr    = '0;
            chk_addr_nxt = '0;
            state_nxt    = S_SCAN;
          end else if (req_idx >= INDEX_END) begin
            res_index_nxt  = '0;
            res_status_nxt = ST_RANGE;
            state_nxt      = S_RESP;
          end else begin
            mem_re       = 1'b1;
            mem_raddr    = req_idx[IDX_W-1:BIT_W];
            chk_addr_nxt = req_idx[IDX_W-1:BIT_W];
            free_bit_nxt = req_idx[BIT_W-1:0];
            state_nxt    = S_FREE;
          end
        end
      end

      // One word per cycle: check the word read, fetch the next
      S_SCAN: begin
        if (has_zero) begin
          res_index_nxt = '0;
          if (found_idx >= alloc_limit_r) begin
            res_status_nxt = ST_NO_SPACE;
          end else begin
            mem_we         = 1'b1;
            mem_wdata      = mem_rdata_r | (word_t'(1) << ffz);
            res_index_nxt  = found_idx;
            res_status_nxt = ST_OK;
          end
          state_nxt = S_RESP;
        end else if (chk_addr_r == LAST_WORD) begin
          res_index_nxt  = '0;
          res_status_nxt = ST_NO_SPACE;
          state_nxt      = S_RESP;
        end else begin
          mem_re       = 1'b1;
          chk_addr_nxt = chk_addr_r + addr_t'(1);
        end
      end

      // Read-modify-write of the freed word
      S_FREE: begin
        mem_we         = 1'b1;
        mem_wdata      = mem_rdata_r & ~(word_t'(1) << free_bit_r);
        res_index_nxt  = '0;
        res_status_nxt = ST_OK;
        state_nxt      = S_RESP;
      end

      S_RESP: begin
        if (!out_valid_r || out_tready) begin
          load_out  = 1'b1;
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_index_r  <= res_index_r;
      out_status_r <= res_status_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, out_index_r};
  assign out_tuser  = out_status_r;

  // Checks
  a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_CLEAR |-> !in_tready)
    else $error("input accepted during clearing pass");

  a_no_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> (state_r != S_IDLE && state_r != S_RESP))
    else $error("bitmap write outside an update step");

  a_write_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> mem_waddr <= LAST_WORD)
    else $error("bitmap write address beyond last word");

  a_alloc_below_limit: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == ST_OK && out_tdata[IDX_W-1:0] != '0
      |-> out_tdata[IDX_W-1:0] < alloc_limit_r)
    else $error("allocated block at or above limit");

  a_fail_zero_index: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == ST_NO_SPACE || out_tuser == ST_RANGE)
      |-> out_tdata == '0)
    else $error("failed transaction returned nonzero index");

  a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    load_out |-> (!out_valid_r || out_tready))
    else $error("output register overwritten while full");

endmodule

[verif/bba_checker.sv]
`timescale 1ns / 1ps

// Watches the request, result and limit ports of the allocator, keeps its own
// copy of the usage bitmap and compares every result transaction in order.
module bba_checker
  import bba_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [15:0] in_tdata,
  input  logic        in_tuser,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [15:0] out_tdata,
  input  logic [1:0]  out_tuser,
  input  logic        cfg_wr_en,
  input  logic [14:0] cfg_wr_data,
  output int          mismatches,
  output int          awaiting,
  output int          granted,
  output int          refused,
  output int          out_of_range,
  output int          frees
);

  typedef struct packed {
    logic    free_op;
    index_t  block;
    status_t status;
  } grant_t;

  bit [TOTAL_BLOCKS-1:0] used_map;
  index_t                limit_reg;
  grant_t                awaited_grants[$];

  // One line per mismatch
  task automatic report_mismatch(input string what);
    $display("[%0t] mismatch: %s", $realtime, what);
    mismatches++;
  endtask

  // Apply one request to the shadow bitmap and return the result it must give
  function automatic grant_t serve_request(input logic op, input index_t block);
    grant_t g;
    int     first_clear;
    g.free_op = op;
    g.block   = '0;
    g.status  = ST_OK;
    first_clear = TOTAL_BLOCKS;
    if (op == OP_ALLOC) begin
      for (int b = 0; b < TOTAL_BLOCKS; b++) begin
        if (!used_map[b]) begin
          first_clear = b;
          break;
        end
      end
      if (first_clear >= TOTAL_BLOCKS || first_clear >= int'(limit_reg)) begin
        g.status = ST_NO_SPACE;
      end else begin
        used_map[first_clear] = 1'b1;
        g.block = index_t'(first_clear);
      end
    end else begin
      if (int'(block) >= TOTAL_BLOCKS)
        g.status = ST_RANGE;
      else
        used_map[block] = 1'b0;  // cleared even if already clear or reserved
    end
    return g;
  endfunction

  initial begin
    mismatches   = 0;
    awaiting     = 0;
    granted      = 0;
    refused      = 0;
    out_of_range = 0;
    frees        = 0;
  end

  always @(posedge clk) begin
    grant_t exp_g;
    if (!rst_n) begin
      used_map = '0;
      for (int b = 0; b < RESERVED_BLOCKS; b++)
        used_map[b] = 1'b1;
      limit_reg = LIMIT_RESET;
      awaited_grants.delete();
    end else begin
      // limit register update
      if (cfg_wr_en)
        limit_reg = cfg_wr_data;

      // accepted request transaction
      if (in_tvalid && in_tready)
        awaited_grants.push_back(serve_request(in_tuser, in_tdata[IDX_W-1:0]));

      // accepted result transaction
      if (out_tvalid && out_tready) begin
        if (awaited_grants.size() == 0) begin
          report_mismatch($sformatf("result with nothing awaited: tdata %0d tuser %0d",
                                    out_tdata, out_tuser));
        end else begin
          exp_g = awaited_grants.pop_front();
          case (exp_g.status)
            ST_OK: begin
              if (exp_g.free_op == OP_FREE) frees++;
              else granted++;
            end
            ST_NO_SPACE: refused++;
            default:     out_of_range++;
          endcase
          if (out_tdata !== {1'b0, exp_g.block})
            report_mismatch($sformatf("allocated_index got %0d, want %0d",
                                      out_tdata, exp_g.block));
          if (out_tuser !== exp_g.status)
            report_mismatch($sformatf("status got %0d, want %0d",
                                      out_tuser, exp_g.status));
        end
      end
    end
    awaiting = awaited_grants.size();
  end

endmodule

[verif/testbench.sv]
`timescale 1ns / 1ps

module testbench;
  import bba_pkg::*;

  localparam int HOLD_CYCLES   = 300;
  localparam int PHASE_ITEMS   = 275;
  localparam int SETTLE_CYCLES = 8;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [15:0] in_tdata;
  logic        in_tuser;
  logic        out_tvalid;
  logic        out_tready;
  logic [15:0] out_tdata;
  logic [1:0]  out_tuser;
  logic        cfg_wr_en;
  logic [14:0] cfg_wr_data;

  int mismatches, awaiting, granted, refused, out_of_range, frees;
  int send_idle_pct;
  int recv_stall_pct;
  int limit_writes;
  int sent;
  bit hold_request;

  bitmap_block_allocator dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  bba_checker chk (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_tvalid    (in_tvalid),
    .in_tready    (in_tready),
    .in_tdata     (in_tdata),
    .in_tuser     (in_tuser),
    .out_tvalid   (out_tvalid),
    .out_tready   (out_tready),
    .out_tdata    (out_tdata),
    .out_tuser    (out_tuser),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .mismatches   (mismatches),
    .awaiting     (awaiting),
    .granted      (granted),
    .refused      (refused),
    .out_of_range (out_of_range),
    .frees        (frees)
  );

  // Clock
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Run limit
  initial begin
    #8_000_000;
    $display("** bitmap_block_allocator: FAILED **");
    $finish;
  end

  // Result side: random stalls, plus one long counted hold on request
  initial begin : result_sink
    int k;
    out_tready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        out_tready <= 1'b0;
        for (k = 0; k < HOLD_CYCLES; k++)
          @(posedge clk);
      end
      out_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Offer one request transaction and wait until it is taken
  task automatic send_item(input logic op, input index_t block);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {1'b0, block};
    @(posedge clk);
    while (!in_tready)
      @(posedge clk);
    sent++;
  endtask

  // Drain all outstanding results, then write a new allocation limit
  task automatic set_limit(input index_t value);
    in_tvalid <= 1'b0;
    do @(posedge clk); while (awaiting != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    limit_writes++;
  endtask

  // Random request: frees mostly land in the low, busy part of the disk
  task automatic random_item();
    int     r;
    index_t block;
    r = $urandom_range(99);
    if ($urandom_range(99) < 45) begin
      send_item(OP_ALLOC, index_t'($urandom));
    end else begin
      if (r < 60)      block = index_t'($urandom_range(511));
      else if (r < 80) block = index_t'($urandom);
      else if (r < 90) block = index_t'($urandom_range(TOTAL_BLOCKS - 1));
      else             block = index_t'($urandom_range(32767, TOTAL_BLOCKS));
      send_item(OP_FREE, block);
    end
  endtask

  initial begin : stimulus
    int idle_mix  [4];
    int stall_mix [4];
    index_t phase_limit;
    idle_mix       = '{0, 71, 0, 16};
    stall_mix      = '{0, 0, 71, 16};
    rst_n          = 1'b0;
    in_tvalid      = 1'b0;
    in_tdata       = '0;
    in_tuser       = OP_ALLOC;
    cfg_wr_en      = 1'b0;
    cfg_wr_data    = '0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_request   = 1'b0;
    limit_writes   = 0;
    sent           = 0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: reset limit, reserved blocks, repeated and out-of-range frees
    send_item(OP_ALLOC, 15'h7FFF);
    send_item(OP_ALLOC, 15'd0);
    send_item(OP_FREE,  15'd0);
    send_item(OP_ALLOC, 15'd0);
    send_item(OP_FREE,  15'd5);
    send_item(OP_FREE,  15'd5);
    send_item(OP_ALLOC, 15'd0);
    send_item(OP_FREE,  15'd20480);
    send_item(OP_FREE,  15'h7FFF);
    send_item(OP_FREE,  15'd20479);
    send_item(OP_FREE,  15'd16384);
    send_item(OP_FREE,  15'd8);
    send_item(OP_FREE,  15'h5555);
    send_item(OP_FREE,  15'h2AAA);
    send_item(OP_FREE,  15'd7);
    send_item(OP_ALLOC, 15'd0);

    // Limit of zero: every allocate refused and leaves the bitmap untouched
    set_limit(15'd0);
    send_item(OP_ALLOC, 15'd0);
    send_item(OP_FREE,  15'd6);
    send_item(OP_ALLOC, 15'd0);

    // Limit right above the lowest free block, then below the next one
    set_limit(15'd7);
    send_item(OP_ALLOC, 15'd0);
    send_item(OP_ALLOC, 15'd0);

    // Limit beyond the end of the disk
    set_limit(15'h7FFF);
    send_item(OP_ALLOC, 15'd0);
    send_item(OP_ALLOC, 15'd0);

    // Random phases over the idle/stall mixes
    for (int p = 0; p < 4; p++) begin
      case (p)
        0:       phase_limit = INDEX_END;
        1:       phase_limit = index_t'($urandom_range(400, 64));
        2:       phase_limit = 15'h7FFF;
        default: phase_limit = index_t'($urandom_range(TOTAL_BLOCKS));
      endcase
      set_limit(phase_limit);
      send_idle_pct  = idle_mix[p];
      recv_stall_pct = stall_mix[p];
      // output held off while requests keep coming, so the block backs up
      if (p == 0)
        hold_request = 1'b1;
      for (int i = 0; i < PHASE_ITEMS; i++)
        random_item();
    end

    // Drain and let the block go quiet
    in_tvalid <= 1'b0;
    do @(posedge clk); while (awaiting != 0);
    repeat (40) @(posedge clk);

    $display("Covered %0d transactions across %0d limit writes, four idle/stall mixes",
             sent, limit_writes);
    $display("  and one %0d-cycle output hold: %0d grants, %0d refusals, %0d frees, %0d range errors",
             HOLD_CYCLES, granted, refused, frees, out_of_range);
    if (mismatches == 0 && awaiting == 0) begin
      $display("** bitmap_block_allocator: PASSED **");
    end else begin
      $display("** bitmap_block_allocator: FAILED **");
    end
    $finish;
  end

endmodule
